// File: rtl/abc_pkg.sv
// Package of the adaptive batch coalescer.
// Holds the payload and control structs, codes and fixed field widths.
// No dependencies; abc_dp, abc_ctrl, the top level and the testbench import it.
package abc_pkg;

  localparam int CNT_W    = 7;   // batch_count, limits and counters
  localparam int IN_H_W   = 16;  // msg_handle and out_handle
  localparam int TIMER_W  = 16;
  localparam int CFG_W    = 16;  // widest configuration register
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]   INIT_LIMIT_RST = 7'd8;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_LIMIT = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_ADAPT_EN   = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_MSG  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CAUSE_SINGLE  = 2'd0,
    CAUSE_LIMIT   = 2'd1,
    CAUSE_FINISH  = 2'd2,
    CAUSE_TIMEOUT = 2'd3
  } cause_e;

  typedef struct packed {
    logic              func;
    logic [IN_H_W-1:0] msg_handle;
    logic              finish_batch;
  } in_item_t;

  typedef struct packed {
    logic [IN_H_W-1:0] out_handle;
    logic [CNT_W-1:0]  batch_count;
    logic              last_of_batch;
    logic [1:0]        flush_cause;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;  // an input request is accepted this cycle
    logic rd;    // read the buffer entry at the walk index
    logic emit;  // load the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_flush;
    logic start_single;
    logic out_free;
    logic last;
  } dp_status_t;

endpackage

// File: rtl/abc_stream_if.sv
// Valid/ready channel of the adaptive batch coalescer.
// Carries one payload of type payload_t, an abc_pkg struct in use; imports nothing.
interface abc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/abc_dp.sv
// Datapath of the adaptive batch coalescer: configuration, timers,
// pending buffer memory, flush walk and output register. Uses abc_pkg.
module abc_dp import abc_pkg::*; #(
  parameter int MAX_BATCH   = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_item_t             item_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o
);

  localparam int IDX_W = $clog2(MAX_BATCH);
  localparam int SUM_W = CNT_W + 2;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BATCH);
  localparam logic [CNT_W-1:0] LIMIT_RST =
    (INIT_LIMIT_RST > MAX_CNT) ? MAX_CNT : INIT_LIMIT_RST;

  logic [CNT_W-1:0]   init_limit_q;
  logic [TIMER_W-1:0] timeout_q;
  logic               adapt_q;
  logic [CNT_W-1:0]   pending_q;
  logic [CNT_W-1:0]   limit_q;
  logic               brun_q;
  logic [TIMER_W-1:0] btimer_q;
  logic [CNT_W-1:0]   ic_q;
  logic [TIMER_W-1:0] atimer_q;
  logic [CNT_W-1:0]   idx_q;
  logic [CNT_W-1:0]   fcnt_q;
  cause_e             cause_q;
  logic [IN_H_W-1:0]  data_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [HANDLE_BITS-1:0] mem [MAX_BATCH];

  logic             is_msg, single, pend_inc, msg_flush, expire, tick_flush;
  logic [CNT_W-1:0] new_cnt, cfg_limit, adapt_limit;
  logic [SUM_W-1:0] adapt_sum;
  cause_e           flush_cause;

  always_comb begin
    is_msg     = (item_i.func == FUNC_MSG);
    single     = is_msg && (init_limit_q == CNT_W'(1));
    pend_inc   = (pending_q < MAX_CNT);
    new_cnt    = pending_q + CNT_W'(pend_inc);
    msg_flush  = is_msg && !single && (item_i.finish_batch || (new_cnt >= limit_q));
    expire     = brun_q && (btimer_q <= TIMER_W'(1));
    tick_flush = !is_msg && expire && (pending_q != '0);
    if (!is_msg) begin
      flush_cause = CAUSE_TIMEOUT;
    end else if (item_i.finish_batch) begin
      flush_cause = CAUSE_FINISH;
    end else begin
      flush_cause = CAUSE_LIMIT;
    end
    cfg_limit   = (cfg_data_i[CNT_W-1:0] > MAX_CNT) ? MAX_CNT : cfg_data_i[CNT_W-1:0];
    // floor((3*limit + count)/4), exact in integers.
    adapt_sum   = SUM_W'(limit_q) + (SUM_W'(limit_q) << 1) + SUM_W'(ic_q);
    adapt_limit = (adapt_sum[SUM_W-1:2] > MAX_CNT) ? MAX_CNT : adapt_sum[SUM_W-1:2];
  end

  assign status_o.start_flush  = msg_flush || tick_flush;
  assign status_o.start_single = single;
  assign status_o.out_free     = !out_valid_q || out_ready_i;
  assign status_o.last         = ((idx_q + CNT_W'(1)) == fcnt_q);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_limit_q <= INIT_LIMIT_RST;
      timeout_q    <= TIMEOUT_RST;
      adapt_q      <= 1'b0;
      pending_q    <= '0;
      limit_q      <= LIMIT_RST;
      brun_q       <= 1'b0;
      btimer_q     <= '0;
      ic_q         <= '0;
      atimer_q     <= TIMEOUT_RST;
      idx_q        <= '0;
      fcnt_q       <= '0;
      cause_q      <= CAUSE_SINGLE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INIT_LIMIT: begin
          init_limit_q <= cfg_data_i[CNT_W-1:0];
          limit_q      <= cfg_limit;
        end
        REG_TIMEOUT: begin
          timeout_q <= cfg_data_i[TIMER_W-1:0];
          atimer_q  <= cfg_data_i[TIMER_W-1:0];
        end
        REG_ADAPT_EN: adapt_q <= cfg_data_i[0];
        default: ;
      endcase
    end else if (cmd_i.take) begin
      if (single) begin
        idx_q   <= '0;
        fcnt_q  <= CNT_W'(1);
        cause_q <= CAUSE_SINGLE;
      end else if (is_msg) begin
        ic_q <= (ic_q < MAX_CNT) ? ic_q + CNT_W'(1) : ic_q;
        if (msg_flush) begin
          pending_q <= '0;
          brun_q    <= 1'b0;
          btimer_q  <= '0;
          idx_q     <= '0;
          fcnt_q    <= new_cnt;
          cause_q   <= flush_cause;
        end else begin
          pending_q <= new_cnt;
          if (!brun_q) begin
            brun_q   <= 1'b1;
            btimer_q <= timeout_q;
          end
        end
      end else begin
        if (expire) begin
          brun_q   <= 1'b0;
          btimer_q <= '0;
          if (tick_flush) begin
            pending_q <= '0;
            idx_q     <= '0;
            fcnt_q    <= pending_q;
            cause_q   <= CAUSE_TIMEOUT;
          end
        end else if (brun_q) begin
          btimer_q <= btimer_q - TIMER_W'(1);
        end
        if (adapt_q) begin
          if (atimer_q <= TIMER_W'(1)) begin
            limit_q  <= adapt_limit;
            ic_q     <= '0;
            atimer_q <= timeout_q;
          end else begin
            atimer_q <= atimer_q - TIMER_W'(1);
          end
        end
      end
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  // Pending buffer: written at the fill position, read during a flush walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_msg && !single && pend_inc) begin
      mem[pending_q[IDX_W-1:0]] <= HANDLE_BITS'(item_i.msg_handle);
    end
    if (cmd_i.rd) begin
      data_q <= IN_H_W'(mem[idx_q[IDX_W-1:0]]);
    end else if (cmd_i.take && single) begin
      data_q <= item_i.msg_handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_handle    <= data_q;
      out_q.batch_count   <= fcnt_q;
      out_q.last_of_batch <= status_o.last;
      out_q.flush_cause   <= cause_q;
    end
  end

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MAX_CNT) else $error("pending count above buffer depth");

  a_timer_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brun_q |-> (pending_q != '0)) else $error("batch timer running on empty buffer");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && !cfg_we_i && status_o.start_flush) |=> (pending_q == '0 && !brun_q))
    else $error("flush did not clear the buffer state");

  a_limit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q <= MAX_CNT) else $error("batch limit above maximum");

endmodule

// File: rtl/abc_ctrl.sv
// Controller of the adaptive batch coalescer: accepts requests, sequences
// the read/emit walk of a flush and the emit of a pass-through. Uses abc_pkg.
module abc_ctrl import abc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign in_ready_o = ready_q;
  assign cmd_o.take = in_valid_i && ready_q;
  assign cmd_o.rd   = (state_q == ST_READ);
  assign cmd_o.emit = (state_q == ST_EMIT) && status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.take && status_i.start_single) begin
            state_q <= ST_EMIT;
            ready_q <= 1'b0;
          end else if (cmd_o.take && status_i.start_flush) begin
            state_q <= ST_READ;
            ready_q <= 1'b0;
          end
        end
        ST_READ: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (cmd_o.emit && status_i.last) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end else if (cmd_o.emit) begin
            state_q <= ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == ST_IDLE)) else $error("ready outside idle");

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> (state_q == ST_EMIT)) else $error("read not followed by emit");

  a_no_take_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_o.take) else $error("request taken during a flush");

endmodule

// File: rtl/adaptive_batch_coalescer.sv
// Top level of the adaptive batch coalescer.
// Uses abc_pkg, abc_stream_if, abc_ctrl and abc_dp.
//
// Requests arrive on item_if: a message (func 0) with its handle and a
// finish flag, or one time tick (func 1). Released handles leave on
// result_if, one per response, in arrival order, the last of a batch marked.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle: index 0 initial batch limit, 1 timeout ticks, 2 adaptation.
//
// A request that releases nothing is taken and the next can
// follow at once. A request that releases n handles holds item_if.ready low
// while the buffer is walked: each handle takes a registered buffer read
// and then a load of the output register, and ready returns high when the
// last handle is loaded. A pass-through message skips the buffer read.
// The output register lets a request be accepted while
// the last response still waits for the receiver.
// When the receiver stalls, the walk stops at the output register.
// Reset empties the buffer, stops both timers and loads the register
// defaults (limit 8, timeout 1000, adaptation off).
module adaptive_batch_coalescer import abc_pkg::*; #(
  parameter int MAX_BATCH   = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  abc_stream_if.sink           item_if,
  abc_stream_if.source         result_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   item;
  out_item_t  result;

  assign item           = item_if.data;
  assign result_if.data = result;

  abc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_if.valid),
    .in_ready_o (item_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  abc_dp #(
    .MAX_BATCH   (MAX_BATCH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (result_if.ready),
    .out_valid_o (result_if.valid),
    .out_item_o  (result)
  );

endmodule

// File: test/adaptive_batch_coalescer_test.sv
// Self-checking testbench of the adaptive batch coalescer.
// Uses abc_pkg and abc_stream_if from the RTL and instantiates adaptive_batch_coalescer.
// A table of directed requests runs first, then random requests across several settings.
module adaptive_batch_coalescer_test;
  import abc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BATCH    = 64;
  localparam int HANDLE_BITS  = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    bit                  is_cfg;
    cfg_reg_e            idx;
    logic [CFG_W-1:0]    val;
    in_item_t            it;
    int                  n_want;  // -1: left to the batch predictor
    out_item_t           want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_reg_e             cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  abc_stream_if #(.payload_t(in_item_t))  item_if ();
  abc_stream_if #(.payload_t(out_item_t)) result_if ();

  adaptive_batch_coalescer #(
    .MAX_BATCH  (MAX_BATCH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_if   (item_if),
    .result_if (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Shadow copy of the block's configuration and batching state.
  logic [CNT_W-1:0]   first_limit;
  logic [TIMER_W-1:0] timeout_cfg;
  logic               adapt_on;
  logic [15:0]        held [MAX_BATCH];
  int                 held_n;
  int                 limit_now;
  bit                 btimer_on;
  int                 btimer;
  int                 msgs_in_period;
  int                 atimer;

  out_item_t released_q[$];
  row_t      rows[$];
  int        errors;
  int        quiet_cycles;
  bit        calm;
  int        row_n_want;
  out_item_t row_want;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 27);
  endfunction

  function automatic int sat_batch(int v);
    return (v > MAX_BATCH) ? MAX_BATCH : v;
  endfunction

  task automatic flag(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void release_batch(cause_e cause);
    out_item_t r;
    for (int i = 0; i < held_n; i++) begin
      r.out_handle    = held[i];
      r.batch_count   = CNT_W'(held_n);
      r.last_of_batch = (i == held_n - 1);
      r.flush_cause   = cause;
      released_q.insert(released_q.size(), r);
    end
    held_n    = 0;
    btimer_on = 1'b0;
    btimer    = 0;
  endfunction

  function automatic void load_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_INIT_LIMIT: begin
        first_limit = val[CNT_W-1:0];
        limit_now   = sat_batch(int'(first_limit));
      end
      REG_TIMEOUT: begin
        timeout_cfg = val[TIMER_W-1:0];
        atimer      = int'(timeout_cfg);
      end
      REG_ADAPT_EN: adapt_on = val[0];
      default: ;
    endcase
  endfunction

  // Works out the handles that one accepted request releases.
  function automatic void coalesce(in_item_t it);
    out_item_t r;
    if (it.func == FUNC_MSG) begin
      if (first_limit == 1) begin
        r.out_handle    = it.msg_handle;
        r.batch_count   = CNT_W'(1);
        r.last_of_batch = 1'b1;
        r.flush_cause   = CAUSE_SINGLE;
        released_q.insert(released_q.size(), r);
        return;
      end
      msgs_in_period = sat_batch(msgs_in_period + 1);
      if (held_n < MAX_BATCH) begin
        held[held_n] = it.msg_handle;
        held_n++;
      end
      if (it.finish_batch) release_batch(CAUSE_FINISH);
      else if (held_n >= limit_now) release_batch(CAUSE_LIMIT);
      else if (!btimer_on) begin
        btimer_on = 1'b1;
        btimer    = int'(timeout_cfg);
      end
      return;
    end
    // A tick: the batch timeout is handled before the limit adjustment.
    if (btimer_on) begin
      if (btimer <= 1) begin
        btimer_on = 1'b0;
        btimer    = 0;
        if (held_n > 0) release_batch(CAUSE_TIMEOUT);
      end else begin
        btimer--;
      end
    end
    if (adapt_on) begin
      if (atimer <= 1) begin
        limit_now      = sat_batch((3 * limit_now + msgs_in_period) / 4);
        msgs_in_period = 0;
        atimer         = int'(timeout_cfg);
      end else begin
        atimer--;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    int        n0;
    out_item_t w;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !roll_idle();
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (item_if.valid && item_if.ready) begin
        n0 = released_q.size();
        coalesce(item_if.data);
        // Typed table rows cross-check what the predictor released.
        if (row_n_want >= 0 && (released_q.size() - n0 != row_n_want ||
            (row_n_want == 1 && released_q[n0] != row_want))) begin
          flag("directed row", released_q.size() - n0, row_n_want);
        end
      end
      if (result_if.valid && result_if.ready) begin
        if (released_q.size() == 0) begin
          flag("unexpected handle", 32'(result_if.data.out_handle), 0);
        end else begin
          w = released_q.pop_front();
          if (result_if.data.out_handle != w.out_handle)
            flag("out_handle", 32'(result_if.data.out_handle), 32'(w.out_handle));
          if (result_if.data.batch_count != w.batch_count)
            flag("batch_count", 32'(result_if.data.batch_count), 32'(w.batch_count));
          if (result_if.data.last_of_batch != w.last_of_batch)
            flag("last_of_batch", 32'(result_if.data.last_of_batch),
                 32'(w.last_of_batch));
          if (result_if.data.flush_cause != w.flush_cause)
            flag("flush_cause", 32'(result_if.data.flush_cause), 32'(w.flush_cause));
        end
      end
    end
  end

  function automatic void row_item(logic func, logic [15:0] h, logic fin, int n_want,
                                   logic [15:0] want_h = '0, cause_e want_c = CAUSE_SINGLE);
    row_t r;
    r.is_cfg                = 1'b0;
    r.idx                   = REG_UNUSED;
    r.val                   = '0;
    r.it.func               = func;
    r.it.msg_handle         = h;
    r.it.finish_batch       = fin;
    r.n_want                = n_want;
    r.want.out_handle       = want_h;
    r.want.batch_count      = CNT_W'(1);
    r.want.last_of_batch    = 1'b1;
    r.want.flush_cause      = want_c;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void row_cfg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.it     = '0;
    r.n_want = -1;
    r.want   = '0;
    rows.insert(rows.size(), r);
  endfunction

  task automatic push_item(in_item_t it, int n_want, out_item_t want);
    while (roll_idle()) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    row_n_want    <= n_want;
    row_want      <= want;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // Waits until every released handle has arrived and the block has gone quiet.
  task automatic settle();
    item_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (released_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    load_reg(idx, val);
  endtask

  task automatic run_phase(int lim, int tmo, int adapt, int n_items, int tick_pct,
                           int fin_pct);
    in_item_t it;
    settle();
    write_reg(REG_INIT_LIMIT, CFG_W'(lim));
    write_reg(REG_TIMEOUT, CFG_W'(tmo));
    write_reg(REG_ADAPT_EN, CFG_W'(adapt));
    cfg_we_i <= 1'b0;
    repeat (n_items) begin
      it.func         = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_MSG;
      it.msg_handle   = 16'($urandom);
      it.finish_batch = ($urandom_range(99) < fin_pct);
      push_item(it, -1, '0);
    end
  endtask

  initial begin : stim
    bit cfg_open;
    cfg_open        = 1'b0;
    errors          = 0;
    quiet_cycles    = 0;
    calm            = 1'b0;
    row_n_want      = -1;
    row_want        = '0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx         = REG_INIT_LIMIT;
    cfg_data        = '0;
    item_if.valid   = 1'b0;
    item_if.data    = '0;

    first_limit    = INIT_LIMIT_RST;
    timeout_cfg    = TIMEOUT_RST;
    adapt_on       = 1'b0;
    held_n         = 0;
    limit_now      = int'(INIT_LIMIT_RST);
    btimer_on      = 1'b0;
    btimer         = 0;
    msgs_in_period = 0;
    atimer         = int'(TIMEOUT_RST);

    // Reset defaults: limit 8, timeout 1000, adaptation off.
    row_item(FUNC_MSG, 16'hFFFF, 1'b1, 1, 16'hFFFF, CAUSE_FINISH);
    row_item(FUNC_MSG, 16'h0000, 1'b1, 1, 16'h0000, CAUSE_FINISH);
    row_item(FUNC_TICK, 16'hFFFF, 1'b1, 0);
    for (int i = 0; i < 8; i++) row_item(FUNC_MSG, 16'hA5A0 + 16'(i), 1'b0, (i < 7) ? 0 : -1);
    // A zero timeout expires on the very next tick.
    row_cfg(REG_TIMEOUT, 16'd0);
    row_item(FUNC_MSG, 16'h1234, 1'b0, 0);
    row_item(FUNC_TICK, 16'h0000, 1'b0, 1, 16'h1234, CAUSE_TIMEOUT);
    // Pass-through leaves the handle already held to its timeout.
    row_cfg(REG_TIMEOUT, 16'd3);
    row_item(FUNC_MSG, 16'h0F0F, 1'b0, 0);
    row_cfg(REG_INIT_LIMIT, 16'd1);
    row_item(FUNC_MSG, 16'hF0F0, 1'b1, 1, 16'hF0F0, CAUSE_SINGLE);
    row_item(FUNC_TICK, 16'h0000, 1'b0, 0);
    row_item(FUNC_TICK, 16'h0000, 1'b0, 0);
    row_item(FUNC_TICK, 16'h0000, 1'b0, 1, 16'h0F0F, CAUSE_TIMEOUT);
    // A limit of zero flushes every message; finish wins over the limit.
    // The write to the unused index must not turn on pass-through.
    row_cfg(REG_INIT_LIMIT, 16'd0);
    row_cfg(REG_UNUSED, 16'd1);
    row_item(FUNC_MSG, 16'h8001, 1'b0, 1, 16'h8001, CAUSE_LIMIT);
    row_item(FUNC_MSG, 16'h7FFE, 1'b1, 1, 16'h7FFE, CAUSE_FINISH);
    // Adaptation, with both timers expiring on the last tick.
    row_cfg(REG_INIT_LIMIT, 16'd8);
    row_cfg(REG_TIMEOUT, 16'd2);
    row_cfg(REG_ADAPT_EN, 16'd1);
    row_item(FUNC_TICK, 16'h0000, 1'b0, -1);
    row_item(FUNC_TICK, 16'h0000, 1'b0, -1);
    row_item(FUNC_MSG, 16'h5A5A, 1'b0, -1);
    row_item(FUNC_TICK, 16'h0000, 1'b0, -1);
    row_item(FUNC_TICK, 16'h0000, 1'b0, -1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        if (!cfg_open) settle();
        cfg_open = 1'b1;
        write_reg(rows[k].idx, rows[k].val);
      end else begin
        if (cfg_open) cfg_we_i <= 1'b0;
        cfg_open = 1'b0;
        push_item(rows[k].it, rows[k].n_want, rows[k].want);
      end
    end

    run_phase(4, 3, 1, 10, 30, 10);
    run_phase(1, 2, 0, 6, 30, 10);
    // A full batch of the largest size, with both sides always willing.
    calm = 1'b1;
    run_phase(127, 65535, 0, 64, 0, 0);
    calm = 1'b0;
    run_phase(64, 1, 1, 8, 40, 10);
    run_phase($urandom_range(2, 10), $urandom_range(1, 6), $urandom_range(0, 1), 8, 30, 10);
    settle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
